// ===== sv/rhc_pkg.sv =====
// Shared constants and types for the RGB, HSB and CMYK color converter.
package rhc_pkg;

  localparam int CHANNEL_BITS_DEF = 16;
  localparam int DIV_LANES = 2;
  localparam int DIV_LANE_SAT = 0;
  localparam int DIV_LANE_HUE = 1;

  typedef enum logic [2:0] {
    MODE_RGB_HSB  = 3'd0,
    MODE_CMYK_RGB = 3'd1,
    MODE_HSB_RGB  = 3'd2,
    MODE_CMYK_HSB = 3'd3,
    MODE_RGB_CMYK = 3'd4,
    MODE_HSB_CMYK = 3'd5
  } mode_e;

endpackage

// ===== sv/rgb_hsb_cmyk_color_converter.sv =====
// Top level of the RGB, HSB and CMYK color converter.
// Converts one color per beat in the conversion selected by the mode register; channels are
// unsigned fractions of CHANNEL_BITS bits with all ones meaning 1.0. A new beat is taken every
// clock cycle while the output is not held; five stages bring the input to RGB, one stage forms
// the hue and saturation dividends, a divider with one stage per quotient bit follows, and the
// output register holds the result. When the output is held the whole pipeline holds with it.
// Write the mode register only while the block is empty.
module rgb_hsb_cmyk_color_converter import rhc_pkg::*; #(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [2:0]              cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [CHANNEL_BITS-1:0] comp_a_i,
  input  logic [CHANNEL_BITS-1:0] comp_b_i,
  input  logic [CHANNEL_BITS-1:0] comp_c_i,
  input  logic [CHANNEL_BITS-1:0] comp_d_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [CHANNEL_BITS-1:0] res_a_o,
  output logic [CHANNEL_BITS-1:0] res_b_o,
  output logic [CHANNEL_BITS-1:0] res_c_o,
  output logic [CHANNEL_BITS-1:0] res_d_o
);

  localparam int CB = CHANNEL_BITS;
  localparam int DW = CB + 3;
  localparam int SW = 4 * CB + 3;
  localparam logic [CB-1:0] FS = {CB{1'b1}};

  mode_e mode_q;
  logic  en;

  assign en = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_RGB_HSB;
    end else if (cfg_we_i) begin
      mode_q <= mode_e'(cfg_wdata_i);
    end
  end

  logic          f_valid;
  mode_e         f_mode;
  logic [CB-1:0] f_r, f_g, f_b;

  rhc_front #(.CB(CB)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .mode_i  (mode_q),
    .a_i     (comp_a_i),
    .b_i     (comp_b_i),
    .c_i     (comp_c_i),
    .d_i     (comp_d_i),
    .valid_o (f_valid),
    .mode_o  (f_mode),
    .r_o     (f_r),
    .g_o     (f_g),
    .b_o     (f_b)
  );

  logic [CB-1:0]   mx, mn, cc;
  logic [DW-1:0]   cc2, cc4, cc6, h6;
  logic [2*CB-1:0] sat_num;
  logic [2*CB+2:0] hue_num;
  logic [DW-1:0]   hi_d  [DIV_LANES];
  logic [CB-1:0]   lo_d  [DIV_LANES];
  logic [DW-1:0]   den_d [DIV_LANES];
  logic [CB-1:0]   pre [4];

  always_comb begin
    mx = f_r;
    if (f_g > mx) mx = f_g;
    if (f_b > mx) mx = f_b;
    mn = f_r;
    if (f_g < mn) mn = f_g;
    if (f_b < mn) mn = f_b;
    cc  = mx - mn;
    cc2 = {3'b000, cc} << 1;
    cc4 = {3'b000, cc} << 2;
    cc6 = cc4 + cc2;
    if (mx == f_r) begin
      if (f_g >= f_b) h6 = {3'b000, f_g} - {3'b000, f_b};
      else h6 = cc6 - ({3'b000, f_b} - {3'b000, f_g});
    end else if (mx == f_g) begin
      h6 = cc2 + {3'b000, f_b} - {3'b000, f_r};
    end else begin
      h6 = cc4 + {3'b000, f_r} - {3'b000, f_g};
    end
    sat_num = ({cc, {CB{1'b0}}} - {{CB{1'b0}}, cc}) + {{(CB+1){1'b0}}, mx[CB-1:1]};
    hue_num = ({h6, {CB{1'b0}}} - {{CB{1'b0}}, h6}) +
              {{CB{1'b0}}, cc2 + {3'b000, cc}};

    if (mx == '0) begin
      hi_d[DIV_LANE_SAT]  = '0;
      lo_d[DIV_LANE_SAT]  = '0;
      den_d[DIV_LANE_SAT] = DW'(1);
    end else begin
      hi_d[DIV_LANE_SAT]  = {3'b000, sat_num[2*CB-1:CB]};
      lo_d[DIV_LANE_SAT]  = sat_num[CB-1:0];
      den_d[DIV_LANE_SAT] = {3'b000, mx};
    end
    if (cc == '0) begin
      hi_d[DIV_LANE_HUE]  = '0;
      lo_d[DIV_LANE_HUE]  = '0;
      den_d[DIV_LANE_HUE] = DW'(1);
    end else begin
      hi_d[DIV_LANE_HUE]  = hue_num[2*CB+2:CB];
      lo_d[DIV_LANE_HUE]  = hue_num[CB-1:0];
      den_d[DIV_LANE_HUE] = cc6;
    end

    case (f_mode)
      MODE_RGB_HSB, MODE_CMYK_HSB: begin
        pre[0] = '0; pre[1] = '0; pre[2] = mx; pre[3] = '0;
      end
      MODE_CMYK_RGB, MODE_HSB_RGB: begin
        pre[0] = f_r; pre[1] = f_g; pre[2] = f_b; pre[3] = '0;
      end
      MODE_RGB_CMYK, MODE_HSB_CMYK: begin
        pre[0] = mx - f_r; pre[1] = mx - f_g; pre[2] = mx - f_b; pre[3] = FS - mx;
      end
      default: begin
        pre[0] = '0; pre[1] = '0; pre[2] = '0; pre[3] = '0;
      end
    endcase
  end

  logic          s6_valid_q;
  logic [DW-1:0] s6_hi_q  [DIV_LANES];
  logic [CB-1:0] s6_lo_q  [DIV_LANES];
  logic [DW-1:0] s6_den_q [DIV_LANES];
  logic [SW-1:0] s6_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_valid_q <= 1'b0;
    end else if (en) begin
      s6_valid_q <= f_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s6_hi_q   <= hi_d;
      s6_lo_q   <= lo_d;
      s6_den_q  <= den_d;
      s6_side_q <= {f_mode, pre[0], pre[1], pre[2], pre[3]};
    end
  end

  logic          d_valid;
  logic [CB-1:0] d_quot [DIV_LANES];
  logic [SW-1:0] d_side;

  rhc_div_pipe #(.CB(CB), .DW(DW), .SW(SW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s6_valid_q),
    .hi_i    (s6_hi_q),
    .lo_i    (s6_lo_q),
    .den_i   (s6_den_q),
    .side_i  (s6_side_q),
    .valid_o (d_valid),
    .quot_o  (d_quot),
    .side_o  (d_side)
  );

  mode_e         d_mode;
  logic [CB-1:0] res_d [4];

  always_comb begin
    d_mode = mode_e'(d_side[SW-1 -: 3]);
    res_d[0] = d_side[4*CB-1 -: CB];
    res_d[1] = d_side[3*CB-1 -: CB];
    res_d[2] = d_side[2*CB-1 -: CB];
    res_d[3] = d_side[CB-1:0];
    case (d_mode)
      MODE_RGB_HSB, MODE_CMYK_HSB: begin
        res_d[0] = d_quot[DIV_LANE_HUE];
        res_d[1] = d_quot[DIV_LANE_SAT];
      end
      default: ;
    endcase
  end

  logic          out_valid_q;
  mode_e         out_mode_q;
  logic [CB-1:0] out_res_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= d_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_mode_q <= d_mode;
      out_res_q  <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_a_o = out_res_q[0];
  assign res_b_o = out_res_q[1];
  assign res_c_o = out_res_q[2];
  assign res_d_o = out_res_q[3];

  a_key_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_mode_q != MODE_RGB_CMYK) && (out_mode_q != MODE_HSB_CMYK)
    |-> (res_d_o == '0))
    else $error("key channel set for a mode without CMYK result");

  a_cmyk_has_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((out_mode_q == MODE_RGB_CMYK) || (out_mode_q == MODE_HSB_CMYK))
    |-> ((res_a_o == '0) || (res_b_o == '0) || (res_c_o == '0)))
    else $error("CMYK result without a zero color channel");

endmodule

// ===== sv/rhc_front.sv =====
// Front pipeline: CMYK and HSB inputs brought to RGB, RGB inputs passed through, in five register stages.
module rhc_front import rhc_pkg::*; #(
  parameter int CB = CHANNEL_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  mode_e         mode_i,
  input  logic [CB-1:0] a_i,
  input  logic [CB-1:0] b_i,
  input  logic [CB-1:0] c_i,
  input  logic [CB-1:0] d_i,
  output logic          valid_o,
  output mode_e         mode_o,
  output logic [CB-1:0] r_o,
  output logic [CB-1:0] g_o,
  output logic [CB-1:0] b_o
);

  localparam logic [CB-1:0]   FS   = {CB{1'b1}};
  localparam logic [CB+2:0]   FSW  = {3'b000, FS};
  localparam logic [2*CB-1:0] HALF = {{(CB+1){1'b0}}, FS[CB-1:1]};

  function automatic logic [CB-1:0] div_fs(input logic [2*CB-1:0] x);
    logic [2*CB:0] s;
    s = {1'b0, x} + {{(CB+1){1'b0}}, x[2*CB-1:CB]} + {{(2*CB){1'b0}}, 1'b1};
    return s[2*CB-1:CB];
  endfunction

  function automatic logic [CB-1:0] cmyk_ch(input logic [CB-1:0] col,
                                            input logic [CB-1:0] k);
    logic [CB:0] s;
    s = {1'b0, col} + {1'b0, k};
    return (s >= {1'b0, FS}) ? '0 : (FS - s[CB-1:0]);
  endfunction

  logic          s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q, s5_valid_q;
  mode_e         s1_mode_q, s2_mode_q, s3_mode_q, s4_mode_q, s5_mode_q;
  logic [CB-1:0] s1_rgb_q [3];
  logic [CB-1:0] s2_rgb_q [3];
  logic [CB-1:0] s3_rgb_q [3];
  logic [CB-1:0] s4_rgb_q [3];
  logic [CB-1:0] s5_rgb_q [3];
  logic [2:0]    s1_sec_q, s2_sec_q, s3_sec_q, s4_sec_q;
  logic [CB-1:0] s1_fsd_q, s2_fsd_q;
  logic [CB-1:0] s1_v_q, s2_v_q, s3_v_q, s4_v_q;
  logic [2*CB-1:0] s1_prod_q, s3_prod_q;
  logic [CB-1:0] s2_ch_q, s3_ch_q, s4_ch_q, s4_x_q;

  logic          cmyk_in;
  logic [CB-1:0] rgb_d [3];
  logic [CB+2:0] h6, off, t_full;
  logic [2:0]    sec_d;
  logic [CB:0]   t, dt;
  logic [CB-1:0] fsd_d;

  always_comb begin
    cmyk_in = (mode_i == MODE_CMYK_RGB) || (mode_i == MODE_CMYK_HSB);
    rgb_d[0] = cmyk_in ? cmyk_ch(a_i, d_i) : a_i;
    rgb_d[1] = cmyk_in ? cmyk_ch(b_i, d_i) : b_i;
    rgb_d[2] = cmyk_in ? cmyk_ch(c_i, d_i) : c_i;
    h6 = ({3'b000, a_i} << 2) + ({3'b000, a_i} << 1);
    sec_d = '0;
    for (int k = 1; k <= 6; k++) begin
      if (h6 >= (CB+3)'(k) * FSW) sec_d = 3'(k);
    end
    off = FSW * (CB+3)'({sec_d[2:1], 1'b0});
    t_full = h6 - off;
    t = t_full[CB:0];
    if (t >= {1'b0, FS}) dt = t - {1'b0, FS};
    else dt = {1'b0, FS} - t;
    fsd_d = FS - dt[CB-1:0];
  end

  logic [CB-1:0] base, ra, ga, ba;

  always_comb begin
    base = s4_v_q - s4_ch_q;
    ra = '0;
    ga = '0;
    ba = '0;
    case (s4_sec_q)
      3'd0: begin ra = s4_ch_q; ga = s4_x_q; end
      3'd1: begin ra = s4_x_q; ga = s4_ch_q; end
      3'd2: begin ga = s4_ch_q; ba = s4_x_q; end
      3'd3: begin ga = s4_x_q; ba = s4_ch_q; end
      3'd4: begin ra = s4_x_q; ba = s4_ch_q; end
      default: begin ra = s4_ch_q; ba = s4_x_q; end
    endcase
  end

  logic hsb_in;
  assign hsb_in = (s4_mode_q == MODE_HSB_RGB) || (s4_mode_q == MODE_HSB_CMYK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
      s5_valid_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_mode_q <= mode_i;
      s1_rgb_q  <= rgb_d;
      s1_sec_q  <= sec_d;
      s1_fsd_q  <= fsd_d;
      s1_v_q    <= c_i;
      s1_prod_q <= b_i * c_i;

      s2_mode_q <= s1_mode_q;
      s2_rgb_q  <= s1_rgb_q;
      s2_sec_q  <= s1_sec_q;
      s2_fsd_q  <= s1_fsd_q;
      s2_v_q    <= s1_v_q;
      s2_ch_q   <= div_fs(s1_prod_q + HALF);

      s3_mode_q <= s2_mode_q;
      s3_rgb_q  <= s2_rgb_q;
      s3_sec_q  <= s2_sec_q;
      s3_v_q    <= s2_v_q;
      s3_ch_q   <= s2_ch_q;
      s3_prod_q <= s2_ch_q * s2_fsd_q;

      s4_mode_q <= s3_mode_q;
      s4_rgb_q  <= s3_rgb_q;
      s4_sec_q  <= s3_sec_q;
      s4_v_q    <= s3_v_q;
      s4_ch_q   <= s3_ch_q;
      s4_x_q    <= div_fs(s3_prod_q + HALF);

      s5_mode_q <= s4_mode_q;
      if (hsb_in) begin
        s5_rgb_q[0] <= ra + base;
        s5_rgb_q[1] <= ga + base;
        s5_rgb_q[2] <= ba + base;
      end else begin
        s5_rgb_q <= s4_rgb_q;
      end
    end
  end

  assign valid_o = s5_valid_q;
  assign mode_o  = s5_mode_q;
  assign r_o     = s5_rgb_q[0];
  assign g_o     = s5_rgb_q[1];
  assign b_o     = s5_rgb_q[2];

endmodule

// ===== sv/rhc_div_pipe.sv =====
// Two-lane pipelined restoring divider, one quotient bit per stage, with side data.
module rhc_div_pipe import rhc_pkg::*; #(
  parameter int CB = CHANNEL_BITS_DEF,
  parameter int DW = CHANNEL_BITS_DEF + 3,
  parameter int SW = 4 * CHANNEL_BITS_DEF + 3
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [DW-1:0] hi_i   [DIV_LANES],
  input  logic [CB-1:0] lo_i   [DIV_LANES],
  input  logic [DW-1:0] den_i  [DIV_LANES],
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [CB-1:0] quot_o [DIV_LANES],
  output logic [SW-1:0] side_o
);

  logic          v_q    [CB];
  logic [DW-1:0] rem_q  [CB][DIV_LANES];
  logic [CB-1:0] sh_q   [CB][DIV_LANES];
  logic [DW-1:0] den_q  [CB][DIV_LANES];
  logic [SW-1:0] side_q [CB];
  logic [DW-1:0] rem_d  [CB][DIV_LANES];
  logic [CB-1:0] sh_d   [CB][DIV_LANES];
  logic [DW-1:0] den_d  [CB][DIV_LANES];

  always_comb begin
    logic [DW-1:0] r;
    logic [CB-1:0] s;
    logic [DW:0]   trial;
    for (int k = 0; k < CB; k++) begin
      for (int l = 0; l < DIV_LANES; l++) begin
        r = (k == 0) ? hi_i[l] : rem_q[(k == 0) ? 0 : k-1][l];
        s = (k == 0) ? lo_i[l] : sh_q[(k == 0) ? 0 : k-1][l];
        den_d[k][l] = (k == 0) ? den_i[l] : den_q[(k == 0) ? 0 : k-1][l];
        trial = {r, s[CB-1]};
        if (trial >= {1'b0, den_d[k][l]}) begin
          trial = trial - {1'b0, den_d[k][l]};
          sh_d[k][l] = {s[CB-2:0], 1'b1};
        end else begin
          sh_d[k][l] = {s[CB-2:0], 1'b0};
        end
        rem_d[k][l] = trial[DW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < CB; k++) v_q[k] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
      for (int k = 1; k < CB; k++) v_q[k] <= v_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      sh_q  <= sh_d;
      den_q <= den_d;
      side_q[0] <= side_i;
      for (int k = 1; k < CB; k++) side_q[k] <= side_q[k-1];
    end
  end

  assign valid_o = v_q[CB-1];
  assign quot_o  = sh_q[CB-1];
  assign side_o  = side_q[CB-1];

  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[0] |-> (den_q[0][DIV_LANE_SAT] != '0) && (den_q[0][DIV_LANE_HUE] != '0))
    else $error("divider entered with a zero divisor");

  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[CB-1] |-> (rem_q[CB-1][DIV_LANE_SAT] < den_q[CB-1][DIV_LANE_SAT]) &&
                  (rem_q[CB-1][DIV_LANE_HUE] < den_q[CB-1][DIV_LANE_HUE]))
    else $error("divider remainder not below divisor");

endmodule
